/* design/life_grid_generation_engine_assert.svh */
// Assertion helpers for the life grid engine.
`ifndef LIFE_GRID_GENERATION_ENGINE_ASSERT_SVH
`define LIFE_GRID_GENERATION_ENGINE_ASSERT_SVH

// Same-cycle implication.
`define LGE_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("life grid engine check failed");

// Next-cycle implication.
`define LGE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("life grid engine check failed");

`endif

/* design/lge_pkg.sv */
package lge_pkg;

   localparam int GRID_ROWS    = 64;
   localparam int GRID_COLUMNS = 64;

   localparam int RIDX_W = $clog2(GRID_ROWS);
   localparam int CIDX_W = $clog2(GRID_COLUMNS);

   localparam int OPCODE_W = 2;
   localparam int ROW_W    = 6;
   localparam int COL_W    = 6;

   localparam logic [OPCODE_W-1:0] OP_WRITE   = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_READ    = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_ADVANCE = 2'd2;

   localparam int BIRTH_COUNT = 3;
   localparam int SURVIVE_LOW = 2;

   typedef logic [GRID_COLUMNS-1:0] row_type;

endpackage

/* design/lge_req_if.sv */
interface lge_req_if;
   import lge_pkg::*;

   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [ROW_W-1:0]    row;
   logic [COL_W-1:0]    column;
   logic                write_value;

   modport source (output valid, output opcode, output row, output column,
                   output write_value, input ready);
   modport sink   (input valid, input opcode, input row, input column,
                   input write_value, output ready);
endinterface

/* design/lge_rsp_if.sv */
interface lge_rsp_if;
   logic valid;
   logic ready;
   logic cell_value;
   logic step_done;

   modport source (output valid, output cell_value, output step_done, input ready);
   modport sink   (input valid, input cell_value, input step_done, output ready);
endinterface

/* design/life_grid_generation_engine.sv */
// Life grid engine: a GRID_ROWS x GRID_COLUMNS grid of one-bit cells under
// rule B3/S23, held as one row per word in two row-wide RAMs used ping-pong
// (current grid and next generation). Every transfer on req_chan yields exactly
// one transfer on rsp_chan. For a cell write or read, the row returns from the
// RAM and is selected or modified and written back in S_ACCESS, then the result
// is loaded in S_FIN; a write is a read-modify-write of the whole row. An
// advance reads one row per cycle (GRID_ROWS + 2 reads, the rows above and
// below the grid included for wrap), each returned row completes the next
// generation of the row above it across all columns at once, and the banks
// swap at the end. The result load waits while an earlier result is still
// held on rsp_chan. The input is ready again the cycle after the load. The
// grid is dead after reset with no clearing pass: per-row valid bits mask
// rows of the reset bank that were never written. wrap_mode (csr_wr_data)
// selects toroidal edges and may only be written while the block is idle.
`include "life_grid_generation_engine_assert.svh"

module life_grid_generation_engine (
   input  logic      clock,
   input  logic      reset,
   input  logic      csr_wr_en,
   input  logic      csr_wr_data,
   lge_req_if.sink   req_chan,
   lge_rsp_if.source rsp_chan
);
   import lge_pkg::*;

   localparam int SCNT_W   = $clog2(GRID_ROWS + 3);
   localparam int LAST_TAG = GRID_ROWS + 1;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_ACCESS = 2'd1;
   localparam logic [1:0] S_STEP   = 2'd2;
   localparam logic [1:0] S_FIN    = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic                 wrap_mode_ff;
   logic                 cur_bank_ff;
   logic [GRID_ROWS-1:0] row_valid_ff;
   logic [RIDX_W-1:0]    rd_row_q_ff;
   logic                 op_write_ff;
   logic                 inside_ff;
   logic [RIDX_W-1:0]    row_ff;
   logic [CIDX_W-1:0]    col_ff;
   logic                 wval_ff;
   logic [SCNT_W-1:0]    step_cnt_ff;
   logic [SCNT_W-1:0]    tag_ff;
   logic                 tag_vld_ff;
   row_type              top_ff;
   row_type              mid_ff;
   logic                 pend_cell_ff;
   logic                 pend_done_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_cell_ff;
   logic                 rsp_done_ff;

   logic              req_accept;
   logic              req_inside;
   logic              adv_accept;
   logic              issue;
   logic              step_last;
   logic              step_wr;
   logic              rsp_load;
   logic              rd_en;
   logic [RIDX_W-1:0] rd_addr;
   logic              wr_en;
   logic              wr_bank;
   logic [RIDX_W-1:0] wr_addr;
   row_type           wr_data;
   row_type           rdata0;
   row_type           rdata1;
   row_type           cur_data;
   row_type           step_data;
   row_type           acc_row;
   row_type           nxt_row;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign req_inside     = (int'(req_chan.row) < GRID_ROWS)
                        && (int'(req_chan.column) < GRID_COLUMNS);
   assign adv_accept     = req_accept && (req_chan.opcode == OP_ADVANCE);

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.cell_value = rsp_cell_ff;
   assign rsp_chan.step_done  = rsp_done_ff;

   assign issue     = (state_ff == S_STEP) && (step_cnt_ff <= SCNT_W'(LAST_TAG));
   assign step_last = (state_ff == S_STEP) && tag_vld_ff && (tag_ff == SCNT_W'(LAST_TAG));
   assign step_wr   = (state_ff == S_STEP) && wr_en;
   assign rsp_load  = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_chan.ready);

   // Rows of the reset bank never written read as dead.
   assign cur_data = cur_bank_ff ? rdata1
                   : (row_valid_ff[rd_row_q_ff] ? rdata0 : '0);

   // Rows beyond top and bottom edges are dead without wrap.
   assign step_data = (!wrap_mode_ff && ((tag_ff == '0) || (tag_ff == SCNT_W'(LAST_TAG))))
                    ? '0 : cur_data;

   always_comb begin
      acc_row         = cur_data;
      acc_row[col_ff] = wval_ff;
   end

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = RIDX_W'(req_chan.row);
      if (state_ff == S_IDLE) begin
         rd_en = req_accept && req_inside
              && (req_chan.opcode inside {OP_WRITE, OP_READ});
      end else if (issue) begin
         rd_en = 1'b1;
         if (step_cnt_ff == '0) begin
            rd_addr = RIDX_W'(GRID_ROWS - 1);
         end else if (step_cnt_ff == SCNT_W'(LAST_TAG)) begin
            rd_addr = '0;
         end else begin
            rd_addr = RIDX_W'(step_cnt_ff - SCNT_W'(1));
         end
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_bank = cur_bank_ff;
      wr_addr = row_ff;
      wr_data = acc_row;
      if (state_ff == S_ACCESS) begin
         wr_en = op_write_ff && inside_ff;
      end else if (state_ff == S_STEP) begin
         wr_en   = tag_vld_ff && (tag_ff >= SCNT_W'(2));
         wr_bank = ~cur_bank_ff;
         wr_addr = RIDX_W'(tag_ff - SCNT_W'(2));
         wr_data = nxt_row;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (req_chan.opcode inside {OP_WRITE, OP_READ}) begin
                  state_in = S_ACCESS;
               end else if (req_chan.opcode == OP_ADVANCE) begin
                  state_in = S_STEP;
               end else begin
                  state_in = S_FIN;
               end
            end
         end
         S_ACCESS: state_in = S_FIN;
         S_STEP: begin
            if (step_last) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wrap_mode_ff <= 1'b0;
         cur_bank_ff  <= 1'b0;
         row_valid_ff <= '0;
         tag_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         tag_vld_ff <= issue;
         if (csr_wr_en) begin
            wrap_mode_ff <= csr_wr_data;
         end
         if (step_last) begin
            cur_bank_ff <= ~cur_bank_ff;
         end
         if (wr_en && !wr_bank) begin
            row_valid_ff[wr_addr] <= 1'b1;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_row_q_ff <= rd_addr;
      tag_ff      <= step_cnt_ff;
      if (req_accept) begin
         op_write_ff  <= (req_chan.opcode == OP_WRITE);
         inside_ff    <= req_inside;
         row_ff       <= RIDX_W'(req_chan.row);
         col_ff       <= CIDX_W'(req_chan.column);
         wval_ff      <= req_chan.write_value;
         step_cnt_ff  <= '0;
         pend_cell_ff <= 1'b0;
         pend_done_ff <= 1'b0;
      end else if (issue) begin
         step_cnt_ff <= step_cnt_ff + SCNT_W'(1);
      end
      if (state_ff == S_ACCESS) begin
         pend_cell_ff <= !op_write_ff && inside_ff && cur_data[col_ff];
      end
      if (step_last) begin
         pend_done_ff <= 1'b1;
      end
      // Three-row window slides down one row per returned read.
      if (tag_vld_ff) begin
         top_ff <= mid_ff;
         mid_ff <= step_data;
      end
      if (rsp_load) begin
         rsp_cell_ff <= pend_cell_ff;
         rsp_done_ff <= pend_done_ff;
      end
   end

   lge_ram #(
      .WIDTH (GRID_COLUMNS),
      .DEPTH (GRID_ROWS)
   ) u_bank0 (
      .clock   (clock),
      .wr_en   (wr_en && !wr_bank),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en && !cur_bank_ff),
      .rd_addr (rd_addr),
      .rd_data (rdata0)
   );

   lge_ram #(
      .WIDTH (GRID_COLUMNS),
      .DEPTH (GRID_ROWS)
   ) u_bank1 (
      .clock   (clock),
      .wr_en   (wr_en && wr_bank),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en && cur_bank_ff),
      .rd_addr (rd_addr),
      .rd_data (rdata1)
   );

   lge_row_update u_row_update (
      .wrap_mode (wrap_mode_ff),
      .top_row   (top_ff),
      .mid_row   (mid_ff),
      .bot_row   (step_data),
      .next_row  (nxt_row)
   );

   `LGE_ASSERT_IMPL(a_rsp_single_flag, clock, reset, rsp_valid_ff, !(rsp_cell_ff && rsp_done_ff))
   `LGE_ASSERT_NEXT(a_adv_enters_step, clock, reset, adv_accept, state_ff == S_STEP)
   `LGE_ASSERT_IMPL(a_step_writes_spare, clock, reset, step_wr, wr_bank != cur_bank_ff)
   `LGE_ASSERT_NEXT(a_step_swaps_bank, clock, reset, step_last, cur_bank_ff != $past(cur_bank_ff))

endmodule

/* design/lge_ram.sv */
module lge_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

/* design/lge_row_update.sv */
module lge_row_update (
   input  logic             wrap_mode,
   input  lge_pkg::row_type top_row,
   input  lge_pkg::row_type mid_row,
   input  lge_pkg::row_type bot_row,
   output lge_pkg::row_type next_row
);
   import lge_pkg::*;

   // One lane per column, all columns of the row in parallel.
   for (genvar c = 0; c < GRID_COLUMNS; c++) begin : g_lane
      localparam int  LI     = (c == 0) ? GRID_COLUMNS - 1 : c - 1;
      localparam int  RI     = (c == GRID_COLUMNS - 1) ? 0 : c + 1;
      localparam bit  L_EDGE = (c == 0);
      localparam bit  R_EDGE = (c == GRID_COLUMNS - 1);

      logic       l_ok;
      logic       r_ok;
      logic [3:0] count;

      assign l_ok = wrap_mode || !L_EDGE;
      assign r_ok = wrap_mode || !R_EDGE;

      assign count = 4'(top_row[LI] & l_ok) + 4'(mid_row[LI] & l_ok)
                   + 4'(bot_row[LI] & l_ok) + 4'(top_row[c]) + 4'(bot_row[c])
                   + 4'(top_row[RI] & r_ok) + 4'(mid_row[RI] & r_ok)
                   + 4'(bot_row[RI] & r_ok);

      // Three neighbors: born or survives; two: survives only if live.
      assign next_row[c] = (count == 4'(BIRTH_COUNT))
                        || (mid_row[c] && (count == 4'(SURVIVE_LOW)));
   end

endmodule

/* dv/tb_life_grid_generation_engine.sv */
module tb_life_grid_generation_engine;
   timeunit 1ns;
   timeprecision 1ps;

   import lge_pkg::*;

   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
   localparam logic [ROW_W-1:0]    LAST_ROW  = ROW_W'(GRID_ROWS - 1);
   localparam logic [COL_W-1:0]    LAST_COL  = COL_W'(GRID_COLUMNS - 1);
   localparam int SURVIVE_HIGH  = 3;
   localparam int IDLE_PERCENT  = 36;
   localparam int HOLD_CYCLES   = 150;
   localparam int STALL_LIMIT   = 2000;
   localparam int DRAIN_CYCLES  = 2 * (GRID_ROWS + 4);
   localparam int REPORT_LIMIT  = 10;

   typedef struct packed {
      logic cell_value;
      logic step_done;
   } cell_reply_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   lge_req_if req_chan();
   lge_rsp_if rsp_chan();

   life_grid_generation_engine DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_chan.sink),
      .rsp_chan    (rsp_chan.source)
   );

   always #1 clock = ~clock;

   // shadow copy of the grid and the edge mode
   bit life_now [GRID_ROWS][GRID_COLUMNS];
   bit wrap_on = 1'b0;

   cell_reply_type replies_due[$];
   int  mismatch_count = 0;
   int  stall_cycles   = 0;
   bit  pace_free      = 1'b0;
   bit  hold_pending   = 1'b0;

   function automatic int live_around(int r, int c);
      int total;
      int nr;
      int nc;
      total = 0;
      for (int dr = -1; dr <= 1; dr++) begin
         for (int dc = -1; dc <= 1; dc++) begin
            if (dr == 0 && dc == 0) continue;
            nr = r + dr;
            nc = c + dc;
            if (wrap_on) begin
               nr = (nr + GRID_ROWS) % GRID_ROWS;
               nc = (nc + GRID_COLUMNS) % GRID_COLUMNS;
            end else if (nr < 0 || nr >= GRID_ROWS || nc < 0 || nc >= GRID_COLUMNS) begin
               continue;
            end
            total += life_now[nr][nc];
         end
      end
      return total;
   endfunction

   function automatic void step_generation();
      bit nxt [GRID_ROWS][GRID_COLUMNS];
      int n;
      for (int r = 0; r < GRID_ROWS; r++) begin
         for (int c = 0; c < GRID_COLUMNS; c++) begin
            n = live_around(r, c);
            if (life_now[r][c])
               nxt[r][c] = (n >= SURVIVE_LOW && n <= SURVIVE_HIGH);
            else
               nxt[r][c] = (n == BIRTH_COUNT);
         end
      end
      life_now = nxt;
   endfunction

   function automatic void predict_reply(logic [OPCODE_W-1:0] op, logic [ROW_W-1:0] r,
                                         logic [COL_W-1:0] c, logic v);
      cell_reply_type want;
      bit on_grid;
      want = '0;
      on_grid = (r < GRID_ROWS) && (c < GRID_COLUMNS);
      case (op)
         OP_WRITE: begin
            if (on_grid) life_now[r][c] = v;
         end
         OP_READ: begin
            if (on_grid) want.cell_value = life_now[r][c];
         end
         OP_ADVANCE: begin
            step_generation();
            want.step_done = 1'b1;
         end
         default: ;
      endcase
      replies_due.push_back(want);
   endfunction

   function automatic void note_failure(string what, cell_reply_type want,
                                        cell_reply_type got);
      if (mismatch_count < REPORT_LIMIT)
         $display("%t mismatch (%s): ", $realtime, what,
                  "expected cell_value=%0b step_done=%0b, ", want.cell_value, want.step_done,
                  "got cell_value=%0b step_done=%0b", got.cell_value, got.step_done);
      mismatch_count++;
   endfunction

   task automatic send_cmd(logic [OPCODE_W-1:0] op, logic [ROW_W-1:0] r,
                           logic [COL_W-1:0] c, logic v);
      while (!pace_free && $urandom_range(99) < IDLE_PERCENT) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.opcode      <= op;
      req_chan.row         <= r;
      req_chan.column      <= c;
      req_chan.write_value <= v;
      do @(posedge clock); while (!req_chan.ready);
      predict_reply(op, r, c, v);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
   endtask

   task automatic set_wrap(bit mode);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      wrap_on = mode;
   endtask

   // at least half of the picks land in the outer two rows or columns
   function automatic int border_biased_index();
      int k;
      if ($urandom_range(1)) return $urandom_range(GRID_ROWS - 1);
      k = $urandom_range(3);
      return (k < 2) ? k : GRID_ROWS - 4 + k;
   endfunction

   task automatic test_cleared_after_reset();
      send_cmd(OP_READ, 0, 0, 1'b0);
      send_cmd(OP_READ, LAST_ROW, LAST_COL, 1'b1);
   endtask

   task automatic test_cell_access();
      send_cmd(OP_WRITE, 0, 0, 1'b1);
      send_cmd(OP_WRITE, 0, LAST_COL, 1'b1);
      send_cmd(OP_WRITE, LAST_ROW, 0, 1'b1);
      send_cmd(OP_WRITE, LAST_ROW, LAST_COL, 1'b1);
      send_cmd(OP_READ, LAST_ROW, 0, 1'b0);
      // unused opcode must leave the grid alone
      send_cmd(OP_UNUSED, LAST_ROW, LAST_COL, 1'b0);
      send_cmd(OP_READ, 0, LAST_COL, 1'b0);
   endtask

   // four live corners form a block across the wrap, and starve without it
   task automatic test_corner_wrap();
      set_wrap(1'b1);
      send_cmd(OP_ADVANCE, 0, 0, 1'b0);
      send_cmd(OP_READ, 0, 0, 1'b0);
      send_cmd(OP_READ, LAST_ROW, LAST_COL, 1'b0);
      set_wrap(1'b0);
      send_cmd(OP_ADVANCE, 0, 0, 1'b0);
      send_cmd(OP_READ, 0, 0, 1'b0);
   endtask

   task automatic test_border_birth();
      send_cmd(OP_WRITE, 0, 1, 1'b1);
      send_cmd(OP_WRITE, 0, 2, 1'b1);
      send_cmd(OP_WRITE, 0, 3, 1'b1);
      send_cmd(OP_ADVANCE, 0, 0, 1'b0);
      send_cmd(OP_READ, 1, 2, 1'b0);
      send_cmd(OP_READ, 0, 1, 1'b0);
   endtask

   // results back up behind a stalled receiver, then the sender waits it out
   task automatic test_result_backpressure();
      int r;
      wait_drained();
      r = $urandom_range(GRID_ROWS - 1);
      pace_free    = 1'b1;
      hold_pending = 1'b1;
      for (int k = 0; k < 16; k++) begin
         if (k % 2 == 0)
            send_cmd(OP_WRITE, ROW_W'(r), COL_W'($urandom_range(GRID_COLUMNS - 1)),
                     1'($urandom_range(1)));
         else
            send_cmd(OP_READ, ROW_W'(r), COL_W'($urandom_range(GRID_COLUMNS - 1)), 1'b0);
      end
      pace_free = 1'b0;
      wait_drained();
   endtask

   task automatic test_random_patterns(int bursts);
      int top;
      int left;
      for (int b = 0; b < bursts; b++) begin
         if ($urandom_range(2) == 0) set_wrap(1'($urandom_range(1)));
         pace_free = (b == 2 || b == 3);
         top  = border_biased_index();
         left = border_biased_index();
         repeat ($urandom_range(6, 10))
            send_cmd(OP_WRITE, ROW_W'((top + $urandom_range(4)) % GRID_ROWS),
                     COL_W'((left + $urandom_range(4)) % GRID_COLUMNS),
                     $urandom_range(99) < 65);
         repeat ($urandom_range(1, 3)) send_cmd(OP_ADVANCE, 0, 0, 1'b0);
         repeat (6)
            send_cmd(OP_READ, ROW_W'((top + GRID_ROWS - 1 + $urandom_range(6)) % GRID_ROWS),
                     COL_W'((left + GRID_COLUMNS - 1 + $urandom_range(6)) % GRID_COLUMNS),
                     1'b0);
         repeat ($urandom_range(2))
            send_cmd(OPCODE_W'($urandom_range(3)), ROW_W'($urandom_range(GRID_ROWS - 1)),
                     COL_W'($urandom_range(GRID_COLUMNS - 1)), 1'($urandom_range(1)));
      end
      pace_free = 1'b0;
   endtask

   initial begin
      reset                <= 1'b1;
      csr_wr_en            <= 1'b0;
      csr_wr_data          <= 1'b0;
      req_chan.valid       <= 1'b0;
      req_chan.opcode      <= OP_WRITE;
      req_chan.row         <= '0;
      req_chan.column      <= '0;
      req_chan.write_value <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_cleared_after_reset();
      test_cell_access();
      test_corner_wrap();
      test_border_birth();
      test_result_backpressure();
      test_random_patterns(7);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (replies_due.size() != 0) mismatch_count++;
      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // result receiver: random stalls, plus a long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_left    = HOLD_CYCLES;
            hold_pending = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= pace_free || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   always @(posedge clock) begin
      cell_reply_type got;
      cell_reply_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.cell_value = rsp_chan.cell_value;
         got.step_done  = rsp_chan.step_done;
         if (replies_due.size() == 0) begin
            note_failure("result with nothing pending", '0, got);
         end else begin
            want = replies_due.pop_front();
            if (got.cell_value !== want.cell_value) note_failure("cell_value", want, got);
            if (got.step_done !== want.step_done) note_failure("step_done", want, got);
         end
      end
   end

   // any transfer on either channel counts as progress
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready)
          || (rsp_chan.valid && rsp_chan.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule

/* files.f */
+incdir+design
design/lge_pkg.sv
design/lge_req_if.sv
design/lge_rsp_if.sv
design/lge_ram.sv
design/lge_row_update.sv
design/life_grid_generation_engine.sv
dv/tb_life_grid_generation_engine.sv
